/* hw/rtl/height_to_du_dv_bump_map_macros.svh */
// ----------------------------------------------------------------------------
// height to du/dv bump map assertion macros
// shared concurrent check shorthands, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef HEIGHT_TO_DU_DV_BUMP_MAP_MACROS_SVH
`define HEIGHT_TO_DU_DV_BUMP_MAP_MACROS_SVH

// property holds at every edge
`define HDBM_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent holds in the cycle after antecedent
`define HDBM_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/hdbm_pkg.sv */
// ----------------------------------------------------------------------------
// hdbm_pkg
// shared constants, types and wrap helpers of the height to du/dv bump map
// ----------------------------------------------------------------------------
package hdbm_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CNT_W      = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int DIM_W      = 9;
   localparam int HGT_W      = 8;
   localparam int PIX_W      = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 4 * PIX_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_PX  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_PX = 2'd1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_VERT,
      ST_OUTPUT
   } state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      if (v == '0) begin
         clamp_dim = DIM_W'(1);
      end else if (v > maxv) begin
         clamp_dim = maxv;
      end else begin
         clamp_dim = v;
      end
   endfunction

   function automatic logic at_end(input logic [CNT_W-1:0] v,
                                   input logic [DIM_W-1:0] n);
      at_end = (DIM_W'(v) + DIM_W'(1)) >= n;
   endfunction

   function automatic logic [CNT_W-1:0] wrap_prev(input logic [CNT_W-1:0] v,
                                                  input logic [DIM_W-1:0] n);
      logic [DIM_W-1:0] nm1;
      nm1 = n - DIM_W'(1);
      if (v == '0) begin
         wrap_prev = nm1[CNT_W-1:0];
      end else begin
         wrap_prev = v - CNT_W'(1);
      end
   endfunction

   function automatic logic [CNT_W-1:0] wrap_next(input logic [CNT_W-1:0] v,
                                                  input logic [DIM_W-1:0] n);
      if (at_end(v, n)) begin
         wrap_next = '0;
      end else begin
         wrap_next = v + CNT_W'(1);
      end
   endfunction

   function automatic logic [ADDR_W-1:0] make_addr(input logic [CNT_W-1:0] row,
                                                   input logic [CNT_W-1:0] col);
      make_addr = {row[ROW_W-1:0], col[COL_W-1:0]};
   endfunction

endpackage

/* hw/rtl/hdbm_ram.sv */
// ----------------------------------------------------------------------------
// hdbm_ram
// generic ram, one write port and two read ports with registered read data
// ----------------------------------------------------------------------------
module hdbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

/* hw/rtl/height_to_du_dv_bump_map.sv */
// loads: one height request per cycle, no result
// drain: the two frame memory read ports fetch the horizontal pair when the
//   request is taken, the vertical pair in ST_READ_VERT; ST_OUTPUT registers
//   the result once the output is free and takes the next drain request then
// reset: counters cleared, loading phase, both dimensions 256; frame memory
//   keeps its contents and is not cleared
// ----------------------------------------------------------------------------
// height_to_du_dv_bump_map
// loads a height frame into memory, then drains du/dv bump pixels in raster
// order with toroidal neighbor wrap
// ----------------------------------------------------------------------------
`include "height_to_du_dv_bump_map_macros.svh"

module height_to_du_dv_bump_map (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hdbm_pkg::REQ_DATA_W-1:0]     req_tdata,  // height
   input  logic                                req_tuser,  // req_type
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hdbm_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // delta_u, delta_v, pix_col, pix_row
   output logic                                rsp_tlast,  // last_pixel
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hdbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hdbm_pkg::DIM_W-1:0]          csr_data
);

   hdbm_pkg::state_type state_ff, state_in;

   logic [hdbm_pkg::CNT_W-1:0]      col_ff, col_in, row_ff, row_in;
   logic [hdbm_pkg::CNT_W-1:0]      lcol_ff, lcol_in, lrow_ff, lrow_in;
   logic                            drain_ff, drain_in;
   logic [hdbm_pkg::DIM_W-1:0]      width_ff, width_in, height_ff, height_in;
   logic [hdbm_pkg::HGT_W-1:0]      du_ff, du_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [hdbm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            out_free, finish, req_ready;
   logic                            col_end, row_end, last_px;
   logic [hdbm_pkg::CNT_W-1:0]      adv_col, adv_row, eff_col, eff_row;
   logic                            eff_drain, req_fire, drain_go, load_go, rd_vert;
   logic [hdbm_pkg::HGT_W-1:0]      dv;

   logic                            wr_en;
   logic [hdbm_pkg::ADDR_W-1:0]     wr_addr, rd_addr_a, rd_addr_b;
   logic [hdbm_pkg::HGT_W-1:0]      wr_data, rd_data_a, rd_data_b;

   hdbm_ram #(
      .WIDTH (hdbm_pkg::HGT_W),
      .DEPTH (hdbm_pkg::DEPTH)
   ) u_frame (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_tready;
      finish    = (state_ff == hdbm_pkg::ST_OUTPUT) && out_free;
      col_end   = hdbm_pkg::at_end(col_ff, width_ff);
      row_end   = hdbm_pkg::at_end(row_ff, height_ff);
      last_px   = col_end && row_end;
      adv_col   = col_end ? '0 : col_ff + hdbm_pkg::CNT_W'(1);
      adv_row   = col_end ? (row_end ? '0 : row_ff + hdbm_pkg::CNT_W'(1)) : row_ff;
      eff_col   = finish ? adv_col : col_ff;
      eff_row   = finish ? adv_row : row_ff;
      eff_drain = finish ? !last_px : drain_ff;

      req_ready = (state_ff == hdbm_pkg::ST_IDLE) || finish;
      req_fire  = req_tvalid && req_ready;
      drain_go  = req_fire && (req_tuser == hdbm_pkg::REQ_DRAIN) && eff_drain;
      load_go   = req_fire && (req_tuser == hdbm_pkg::REQ_LOAD) && !eff_drain;
      rd_vert   = (state_ff == hdbm_pkg::ST_READ_VERT) ||
                  ((state_ff == hdbm_pkg::ST_OUTPUT) && !drain_go);

      // horizontal pair on a new pixel, vertical pair after it
      if (rd_vert) begin
         rd_addr_a = hdbm_pkg::make_addr(hdbm_pkg::wrap_prev(row_ff, height_ff), col_ff);
         rd_addr_b = hdbm_pkg::make_addr(hdbm_pkg::wrap_next(row_ff, height_ff), col_ff);
      end else begin
         rd_addr_a = hdbm_pkg::make_addr(eff_row, hdbm_pkg::wrap_prev(eff_col, width_ff));
         rd_addr_b = hdbm_pkg::make_addr(eff_row, hdbm_pkg::wrap_next(eff_col, width_ff));
      end
      dv = rd_data_a - rd_data_b;

      wr_en   = load_go;
      wr_addr = hdbm_pkg::make_addr(lrow_ff, lcol_ff);
      wr_data = req_tdata[hdbm_pkg::HGT_W-1:0];

      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      lcol_in      = lcol_ff;
      lrow_in      = lrow_ff;
      drain_in     = drain_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      du_in        = du_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         hdbm_pkg::ST_IDLE: begin
            if (drain_go) begin
               state_in = hdbm_pkg::ST_READ_VERT;
            end
         end
         hdbm_pkg::ST_READ_VERT: begin
            du_in    = rd_data_a - rd_data_b;
            state_in = hdbm_pkg::ST_OUTPUT;
         end
         hdbm_pkg::ST_OUTPUT: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {row_ff[hdbm_pkg::PIX_W-1:0], col_ff[hdbm_pkg::PIX_W-1:0],
                               dv, du_ff};
               rsp_last_in  = last_px;
               col_in       = adv_col;
               row_in       = adv_row;
               drain_in     = !last_px;
               state_in     = drain_go ? hdbm_pkg::ST_READ_VERT : hdbm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hdbm_pkg::ST_IDLE;
         end
      endcase

      if (load_go) begin
         if (hdbm_pkg::at_end(lcol_ff, width_ff)) begin
            lcol_in = '0;
            if (hdbm_pkg::at_end(lrow_ff, height_ff)) begin
               lrow_in  = '0;
               col_in   = '0;
               row_in   = '0;
               drain_in = 1'b1;
            end else begin
               lrow_in = lrow_ff + hdbm_pkg::CNT_W'(1);
            end
         end else begin
            lcol_in = lcol_ff + hdbm_pkg::CNT_W'(1);
         end
      end

      // width or height register write restarts the frame
      if (csr_valid && (csr_index == hdbm_pkg::CSR_WIDTH_PX ||
                        csr_index == hdbm_pkg::CSR_HEIGHT_PX)) begin
         if (csr_index == hdbm_pkg::CSR_WIDTH_PX) begin
            width_in = hdbm_pkg::clamp_dim(csr_data,
                                           hdbm_pkg::DIM_W'(hdbm_pkg::MAX_WIDTH));
         end else begin
            height_in = hdbm_pkg::clamp_dim(csr_data,
                                            hdbm_pkg::DIM_W'(hdbm_pkg::MAX_HEIGHT));
         end
         col_in   = '0;
         row_in   = '0;
         lcol_in  = '0;
         lrow_in  = '0;
         drain_in = 1'b0;
         state_in = hdbm_pkg::ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hdbm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         lcol_ff      <= '0;
         lrow_ff      <= '0;
         drain_ff     <= 1'b0;
         width_ff     <= hdbm_pkg::DIM_W'(hdbm_pkg::MAX_WIDTH);
         height_ff    <= hdbm_pkg::DIM_W'(hdbm_pkg::MAX_HEIGHT);
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         lcol_ff      <= lcol_in;
         lrow_ff      <= lrow_in;
         drain_ff     <= drain_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      du_ff       <= du_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = req_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_ready  = 1'b1;

   `HDBM_CHECK(a_vert_only_draining, (state_ff != hdbm_pkg::ST_READ_VERT) || drain_ff, "vertical read outside drain")
   `HDBM_CHECK_NEXT(a_vert_then_out, state_ff == hdbm_pkg::ST_READ_VERT && !csr_valid, state_ff == hdbm_pkg::ST_OUTPUT, "vertical read not followed by output")
   `HDBM_CHECK(a_load_idle_in_drain, !drain_ff || (lcol_ff == '0 && lrow_ff == '0), "load counters moved while draining")
   `HDBM_CHECK(a_col_in_range, (hdbm_pkg::DIM_W'(col_ff) < width_ff) && (hdbm_pkg::DIM_W'(lcol_ff) < width_ff), "column beyond width")
   `HDBM_CHECK_NEXT(a_last_ends_frame, finish && last_px && !load_go, !drain_ff, "drain continues after last pixel")

endmodule

/* dv/height_to_du_dv_bump_map_tb.sv */
// ----------------------------------------------------------------------------
// height_to_du_dv_bump_map_tb
// self-checking bench for the height map to du/dv bump map converter: height
// frames of many sizes are loaded and drained through the request stream
// while an internal copy of the frame store predicts every bump pixel.
// register writes, ignored requests and cut-short frames are mixed in, and
// both stream sides idle or stall at random.
// ----------------------------------------------------------------------------
module height_to_du_dv_bump_map_tb;

   import hdbm_pkg::*;

   localparam int RANDOM_ITEMS   = 1550;
   localparam int SETTLE_CYCLES  = 10;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int DIRECTED_ROWS  = 33;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [7:0] delta_u;
      logic [7:0] delta_v;
      logic [7:0] pix_col;
      logic [7:0] pix_row;
      logic       last_pixel;
   } bump_pixel;

   localparam bump_pixel NO_PIXEL = '0;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_e;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

   typedef struct packed {
      row_kind_e            kind;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic                 req_kind;
      logic [DIM_W-1:0]     value;
      logic                 typed;
      bump_pixel            want;
   } stim_row;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [DIM_W-1:0]      csr_data   = '0;

   // predictor state
   logic [7:0]       height_frame [0:MAX_WIDTH*MAX_HEIGHT-1];
   logic [DIM_W-1:0] map_width  = 9'd256;
   logic [DIM_W-1:0] map_height = 9'd256;
   int               fill_col   = 0;
   int               fill_row   = 0;
   int               scan_col   = 0;
   int               scan_row   = 0;
   bit               scanning   = 1'b0;

   bump_pixel  pixels_due [$];
   int         fail_count = 0;
   idle_mode_e idle_mode  = IDLE_BOTH;

   // directed frames: 1x1 after zero writes, 3x1 and 1x3 with extreme heights,
   // then a 2x2 frame restarted once while loading and once while draining
   stim_row directed_stim [0:DIRECTED_ROWS-1] = '{
      '{ROW_CSR, CSR_WIDTH_PX,  REQ_LOAD,  9'd0,   1'b0, NO_PIXEL},
      '{ROW_CSR, CSR_HEIGHT_PX, REQ_LOAD,  9'd0,   1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_DRAIN, 9'd0,   1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'hFF,  1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'h00,  1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_DRAIN, 9'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1}},
      '{ROW_CSR, CSR_WIDTH_PX,  REQ_LOAD,  9'd3,   1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'hFF,  1'b0, NO_PIXEL},
      '{ROW_CSR, CSR_SPARE_2,   REQ_LOAD,  9'h1FF, 1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'h00,  1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'h00,  1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_DRAIN, 9'd0,   1'b1, '{8'd0,   8'd0, 8'd0, 8'd0, 1'b0}},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_DRAIN, 9'd0,   1'b1, '{8'd255, 8'd0, 8'd1, 8'd0, 1'b0}},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_DRAIN, 9'd0,   1'b1, '{8'd1,   8'd0, 8'd2, 8'd0, 1'b1}},
      '{ROW_CSR, CSR_WIDTH_PX,  REQ_LOAD,  9'd1,   1'b0, NO_PIXEL},
      '{ROW_CSR, CSR_HEIGHT_PX, REQ_LOAD,  9'd3,   1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'h00,  1'b0, NO_PIXEL},
      '{ROW_CSR, CSR_SPARE_3,   REQ_LOAD,  9'd0,   1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'hFF,  1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'h00,  1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_DRAIN, 9'd0,   1'b1, '{8'd0, 8'd1,   8'd0, 8'd0, 1'b0}},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_DRAIN, 9'd0,   1'b1, '{8'd0, 8'd0,   8'd0, 8'd1, 1'b0}},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_DRAIN, 9'd0,   1'b1, '{8'd0, 8'd255, 8'd0, 8'd2, 1'b1}},
      '{ROW_CSR, CSR_WIDTH_PX,  REQ_LOAD,  9'd2,   1'b0, NO_PIXEL},
      '{ROW_CSR, CSR_HEIGHT_PX, REQ_LOAD,  9'd2,   1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'hA5,  1'b0, NO_PIXEL},
      '{ROW_CSR, CSR_WIDTH_PX,  REQ_LOAD,  9'd2,   1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'h5A,  1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'h0F,  1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'hF0,  1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_LOAD,  9'h81,  1'b0, NO_PIXEL},
      '{ROW_REQ, CSR_WIDTH_PX,  REQ_DRAIN, 9'd0,   1'b0, NO_PIXEL},
      '{ROW_CSR, CSR_HEIGHT_PX, REQ_LOAD,  9'd2,   1'b0, NO_PIXEL}
   };

   height_to_du_dv_bump_map DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
      if (v == '0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic void restart_frame();
      fill_col = 0;
      fill_row = 0;
      scan_col = 0;
      scan_row = 0;
      scanning = 1'b0;
   endfunction

   function automatic bit predict_bump_pixel(input logic kind, input logic [7:0] hgt,
                                             output bump_pixel px);
      int w, h, lft, rgt, up, dn;
      w  = eff_dim(map_width, MAX_WIDTH);
      h  = eff_dim(map_height, MAX_HEIGHT);
      px = NO_PIXEL;
      if (kind == REQ_LOAD) begin
         if (scanning) return 1'b0;
         height_frame[fill_row * MAX_WIDTH + fill_col] = hgt;
         fill_col++;
         if (fill_col >= w) begin
            fill_col = 0;
            fill_row++;
            if (fill_row >= h) begin
               fill_row = 0;
               scan_col = 0;
               scan_row = 0;
               scanning = 1'b1;
            end
         end
         return 1'b0;
      end
      if (!scanning) return 1'b0;
      // toroidal neighbors
      lft = (scan_col == 0) ? w - 1 : scan_col - 1;
      rgt = (scan_col + 1 >= w) ? 0 : scan_col + 1;
      up  = (scan_row == 0) ? h - 1 : scan_row - 1;
      dn  = (scan_row + 1 >= h) ? 0 : scan_row + 1;
      px.delta_u    = height_frame[scan_row * MAX_WIDTH + lft]
                    - height_frame[scan_row * MAX_WIDTH + rgt];
      px.delta_v    = height_frame[up * MAX_WIDTH + scan_col]
                    - height_frame[dn * MAX_WIDTH + scan_col];
      px.pix_col    = 8'(scan_col);
      px.pix_row    = 8'(scan_row);
      px.last_pixel = (scan_col + 1 >= w) && (scan_row + 1 >= h);
      scan_col++;
      if (scan_col >= w) begin
         scan_col = 0;
         scan_row++;
      end
      if (px.last_pixel) restart_frame();
      return 1'b1;
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim(input bit narrow);
      if (narrow) return DIM_W'($urandom_range(0, 2));
      case ($urandom_range(0, 63))
         0: return 9'd0;
         1: return 9'h1FF;
         2: return DIM_W'($urandom_range(17, 511));
         default: return DIM_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR: %s", msg);
   endfunction

   task automatic send_request(input logic kind, input logic [7:0] hgt, input bit typed,
                               input bump_pixel typed_px);
      bump_pixel px;
      @(negedge clock);
      while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 63) ||
             (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 34)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= hgt;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_bump_pixel(kind, hgt, px)) pixels_due.push_back(typed ? typed_px : px);
   endtask

   // register writes only once every pending pixel is out and the block settled
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pixels_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_WIDTH_PX) begin
         map_width = val;
         restart_frame();
      end else if (idx == CSR_HEIGHT_PX) begin
         map_height = val;
         restart_frame();
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_tready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 63) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 34));
   end

   always @(posedge clock) begin : check_pixels
      bump_pixel got;
      bump_pixel want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tdata[31:24],
                 rsp_tlast};
         if (pixels_due.size() == 0) begin
            note_failure($sformatf("unexpected pixel du=%h dv=%h col=%0d row=%0d last=%b",
                                   got.delta_u, got.delta_v, got.pix_col, got.pix_row,
                                   got.last_pixel));
         end else begin
            want = pixels_due.pop_front();
            if (got.delta_u !== want.delta_u || got.delta_v !== want.delta_v ||
                got.pix_col !== want.pix_col || got.pix_row !== want.pix_row ||
                got.last_pixel !== want.last_pixel) begin
               note_failure($sformatf(
                  "pixel mismatch: expected du=%h dv=%h col=%0d row=%0d last=%b, got du=%h dv=%h col=%0d row=%0d last=%b",
                  want.delta_u, want.delta_v, want.pix_col, want.pix_row, want.last_pixel,
                  got.delta_u, got.delta_v, got.pix_col, got.pix_row, got.last_pixel));
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int                   phase;
      int                   counted;
      int                   pixels;
      int                   frames;
      int                   cut;
      int                   step;
      int                   waited;
      bit                   filling;
      logic [DIM_W-1:0]     width_val;
      logic [DIM_W-1:0]     height_val;
      logic [CSR_IDX_W-1:0] redo_idx;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_stim[i]) begin
         if (directed_stim[i].kind == ROW_CSR) begin
            write_register(directed_stim[i].csr_idx, directed_stim[i].value);
         end else begin
            send_request(directed_stim[i].req_kind, directed_stim[i].value[7:0],
                         directed_stim[i].typed, directed_stim[i].want);
         end
      end

      phase   = 0;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         idle_mode = idle_mode_e'(phase % 4);
         // widest row and tallest column forced once each
         if (phase == 2) begin
            width_val  = 9'h1FF;
            height_val = 9'd1;
         end else if (phase == 5) begin
            width_val  = 9'd0;
            height_val = 9'd256;
         end else if ($urandom_range(0, 1)) begin
            width_val  = pick_dim(1'b0);
            height_val = pick_dim(eff_dim(width_val, MAX_WIDTH) > 16);
         end else begin
            height_val = pick_dim(1'b0);
            width_val  = pick_dim(eff_dim(height_val, MAX_HEIGHT) > 16);
         end
         write_register(CSR_WIDTH_PX, width_val);
         write_register(CSR_HEIGHT_PX, height_val);
         pixels = eff_dim(width_val, MAX_WIDTH) * eff_dim(height_val, MAX_HEIGHT);
         frames = (pixels > 64) ? 1 : $urandom_range(1, 3);
         repeat (frames) begin
            cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2 * pixels - 1) : 2 * pixels;
            for (step = 0; step < 2 * pixels; step++) begin
               if (step == cut) begin
                  if ($urandom_range(0, 1)) begin
                     write_register($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                                    DIM_W'($urandom));
                  end else begin
                     // rewrite of a dimension restarts the frame
                     redo_idx = $urandom_range(0, 1) ? CSR_WIDTH_PX : CSR_HEIGHT_PX;
                     write_register(redo_idx, (redo_idx == CSR_WIDTH_PX) ? width_val
                                                                         : height_val);
                     break;
                  end
               end
               filling = (step < pixels);
               if ($urandom_range(0, 11) == 0) begin
                  send_request(filling ? REQ_DRAIN : REQ_LOAD, 8'($urandom), 1'b0, NO_PIXEL);
               end
               send_request(filling ? REQ_LOAD : REQ_DRAIN,
                            ($urandom_range(0, 7) == 0) ?
                               ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom),
                            1'b0, NO_PIXEL);
               counted++;
            end
         end
         phase++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (pixels_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (pixels_due.size() != 0) begin
         note_failure($sformatf("%0d expected pixels never arrived", pixels_due.size()));
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
